/* hdl/pidc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the PID/PWM unit
// Control word layout, microcode program, register indexes and request codes.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int PC_W = 5;

	// configuration register indexes
	localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [2:0] REG_TERM_LIMIT  = 3'd3;
	localparam logic [2:0] REG_OUT_DIVISOR = 3'd4;

	// request codes
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// x / 25 for x < 2**30 is (x * RCP_MAGIC) >> RCP_SHIFT
	localparam logic [30:0] RCP_MAGIC = 31'd1374389535;
	localparam int          RCP_SHIFT = 35;

	localparam logic [4:0] DIV_STEPS = 5'd17;

	// program addresses
	localparam logic [PC_W-1:0] PC_DIV = 5'd14;
	localparam logic [PC_W-1:0] PC_CLR = 5'd16;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL,
		OP_ABS,
		OP_RECIP,
		OP_TERM,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_OUT,
		OP_CLR
	} op_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_CLR,
		JMP_LOOP
	} jmp_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		op_t             op;
		term_t           term;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		logic            last;
	} ctrl_t;

	typedef struct packed {
		logic clr_req;
		logic div_more;
		logic out_full;
	} seq_stat_t;

	function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w.op     = OP_NOP;
		w.term   = TERM_P;
		w.jmp    = JMP_NONE;
		w.target = '0;
		w.last   = 1'b0;
		case (pc)
			5'd0: begin
				w.jmp    = JMP_CLR;
				w.target = PC_CLR;
			end
			5'd1:  begin w.op = OP_MUL;   w.term = TERM_P; end
			5'd2:  begin w.op = OP_ABS;   w.term = TERM_P; end
			5'd3:  begin w.op = OP_RECIP; w.term = TERM_P; end
			5'd4:  begin w.op = OP_TERM;  w.term = TERM_P; end
			5'd5:  begin w.op = OP_MUL;   w.term = TERM_I; end
			5'd6:  begin w.op = OP_ABS;   w.term = TERM_I; end
			5'd7:  begin w.op = OP_RECIP; w.term = TERM_I; end
			5'd8:  begin w.op = OP_TERM;  w.term = TERM_I; end
			5'd9:  begin w.op = OP_MUL;   w.term = TERM_D; end
			5'd10: begin w.op = OP_ABS;   w.term = TERM_D; end
			5'd11: begin w.op = OP_RECIP; w.term = TERM_D; end
			5'd12: begin w.op = OP_TERM;  w.term = TERM_D; end
			5'd13: begin w.op = OP_DIVINIT; end
			5'd14: begin
				w.op     = OP_DIVSTEP;
				w.jmp    = JMP_LOOP;
				w.target = PC_DIV;
			end
			5'd15: begin
				w.op   = OP_OUT;
				w.last = 1'b1;
			end
			5'd16: begin
				w.op   = OP_CLR;
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

/* hdl/pid_controller_pwm_unit.sv */
`timescale 1ns / 1ps
// Update transaction: duty is registered by the output step at the end of the
// program; no new transaction is taken until the sequencer returns to idle.
// Clear transaction: the clear step zeroes the integrator; no result.
// An update makes three passes through the shared multiplier and
// reciprocal step plus 17 iterations of the serial divider.
// Reset clears gains, integrator and last error; limit 255, divisor 1.
// ----------------------------------------------------------------------------
// pid_controller_pwm_unit: PID controller with clamped terms and PWM duty
// Microcoded datapath with a shared gain multiplier, a reciprocal multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module pid_controller_pwm_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] measured,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         duty,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic signed [15:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [14:0]        term_limit_q;
	logic [15:0]        out_divisor_q;

	logic signed [16:0] err_q, prev_q;
	logic signed [17:0] dlt_q;
	logic               first_q;
	logic               clr_q;
	logic signed [23:0] integ_q;

	logic signed [33:0] prod_q;
	logic               neg_q;
	logic [29:0]        mag_q;
	logic [60:0]        rcp_q;
	logic signed [25:0] acc_q;

	logic [16:0]        num_q;
	logic [15:0]        rem_q;
	logic [4:0]         cnt_q;

	logic               out_valid_q;
	logic [7:0]         duty_q;

	logic               busy;
	logic               in_xact;
	pidc_pkg::ctrl_t    ctrl;
	pidc_pkg::seq_stat_t stat;

	logic signed [16:0] err_in;
	logic signed [17:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [33:0] prod_abs;
	logic [25:0]        q_mag;
	logic signed [26:0] term_val;
	logic signed [27:0] lim_pos, cl_in, cl_out;
	logic signed [23:0] clamped;
	logic [15:0]        dvs;
	logic [16:0]        trial;
	logic               qbit;

	assign in_ready  = !busy;
	assign in_xact   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign duty      = duty_q;

	assign stat.clr_req  = clr_q;
	assign stat.div_more = (cnt_q != 5'd1);
	assign stat.out_full = out_valid_q && !out_ready;

	pidc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xact),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	assign err_in = 17'(setpoint) - 17'(measured);

	always_comb begin
		case (ctrl.term)
			pidc_pkg::TERM_P: begin mul_a = 18'(err_q); mul_b = gain_prop_q;  end
			pidc_pkg::TERM_I: begin mul_a = 18'(err_q); mul_b = gain_integ_q; end
			pidc_pkg::TERM_D: begin mul_a = dlt_q;      mul_b = gain_deriv_q; end
			default:          begin mul_a = 18'(err_q); mul_b = gain_prop_q;  end
		endcase
	end

	assign prod_abs = prod_q[33] ? -prod_q : prod_q;
	assign q_mag    = rcp_q[60:pidc_pkg::RCP_SHIFT];
	assign term_val = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign lim_pos  = $signed({5'b0, term_limit_q, 8'b0});

	always_comb begin
		if (ctrl.term == pidc_pkg::TERM_I) begin
			cl_in = 28'(integ_q) + 28'(term_val);
		end else begin
			cl_in = 28'(term_val);
		end
		if (cl_in > lim_pos) begin
			cl_out = lim_pos;
		end else if (cl_in < -lim_pos) begin
			cl_out = -lim_pos;
		end else begin
			cl_out = cl_in;
		end
	end

	assign clamped = cl_out[23:0];

	assign dvs   = (out_divisor_q == 16'd0) ? 16'd1 : out_divisor_q;
	assign trial = {rem_q, num_q[16]};
	assign qbit  = (trial >= {1'b0, dvs});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q   <= '0;
			gain_integ_q  <= '0;
			gain_deriv_q  <= '0;
			term_limit_q  <= 15'd255;
			out_divisor_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				pidc_pkg::REG_GAIN_PROP:   gain_prop_q   <= cfg_data;
				pidc_pkg::REG_GAIN_INTEG:  gain_integ_q  <= cfg_data;
				pidc_pkg::REG_GAIN_DERIV:  gain_deriv_q  <= cfg_data;
				pidc_pkg::REG_TERM_LIMIT:  term_limit_q  <= cfg_data[14:0];
				pidc_pkg::REG_OUT_DIVISOR: out_divisor_q <= cfg_data;
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			first_q     <= 1'b1;
			clr_q       <= 1'b0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (ctrl.op == pidc_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xact) begin
				clr_q <= (req_type == pidc_pkg::REQ_CLEAR);
				if (req_type == pidc_pkg::REQ_UPDATE) begin
					prev_q  <= err_in;
					first_q <= 1'b0;
				end
			end
			case (ctrl.op)
				pidc_pkg::OP_TERM: begin
					if (ctrl.term == pidc_pkg::TERM_I) integ_q <= clamped;
				end
				pidc_pkg::OP_CLR:     integ_q <= '0;
				pidc_pkg::OP_DIVINIT: cnt_q   <= pidc_pkg::DIV_STEPS;
				pidc_pkg::OP_DIVSTEP: cnt_q   <= cnt_q - 1'b1;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			err_q <= err_in;
			dlt_q <= first_q ? 18'sd0 : 18'(prev_q) - 18'(err_in);
		end
		case (ctrl.op)
			pidc_pkg::OP_MUL: prod_q <= mul_a * mul_b;
			pidc_pkg::OP_ABS: begin
				neg_q <= prod_q[33];
				mag_q <= prod_abs[31:2];
			end
			pidc_pkg::OP_RECIP: rcp_q <= 61'(mag_q) * 61'(pidc_pkg::RCP_MAGIC);
			pidc_pkg::OP_TERM: begin
				if (ctrl.term == pidc_pkg::TERM_P) begin
					acc_q <= 26'(clamped);
				end else begin
					acc_q <= acc_q + 26'(clamped);
				end
			end
			pidc_pkg::OP_DIVINIT: begin
				num_q <= (!acc_q[25] && (acc_q != 26'sd0)) ? acc_q[24:8] : 17'd0;
				rem_q <= '0;
			end
			pidc_pkg::OP_DIVSTEP: begin
				rem_q <= qbit ? 16'(trial - {1'b0, dvs}) : trial[15:0];
				num_q <= {num_q[15:0], qbit};
			end
			pidc_pkg::OP_OUT: duty_q <= (|num_q[16:8]) ? 8'hFF : num_q[7:0];
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !in_ready)
		else $error("sequencer idle after accepted transaction");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == pidc_pkg::OP_DIVSTEP) |-> (cnt_q != 5'd0))
		else $error("divider step with exhausted count");

	a_out_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op == pidc_pkg::OP_OUT))
		else $error("result raised outside the output step");

endmodule

/* hdl/pidc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_seq: microcode sequencer
// Step counter over the control store, conditional jumps and stall on a full
// output register.
// ----------------------------------------------------------------------------
module pidc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pidc_pkg::seq_stat_t stat,
	output logic                busy,
	output pidc_pkg::ctrl_t     ctrl
);

	pidc_pkg::seq_state_t state_q, state_nxt;
	logic [pidc_pkg::PC_W-1:0] pc_q, pc_nxt;
	pidc_pkg::ctrl_t word;
	logic stall;

	assign word  = pidc_pkg::rom_word(pc_q);
	assign stall = (word.op == pidc_pkg::OP_OUT) && stat.out_full;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pidc_pkg::SEQ_IDLE: begin
				if (start) state_nxt = pidc_pkg::SEQ_RUN;
			end
			pidc_pkg::SEQ_RUN: begin
				if (word.last && !stall) state_nxt = pidc_pkg::SEQ_IDLE;
			end
			default: state_nxt = pidc_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		pc_nxt = pc_q + 1'b1;
		case (word.jmp)
			pidc_pkg::JMP_CLR:  if (stat.clr_req) pc_nxt = word.target;
			pidc_pkg::JMP_LOOP: if (stat.div_more) pc_nxt = word.target;
			default:            pc_nxt = pc_q + 1'b1;
		endcase
	end

	always_comb begin
		busy = (state_q == pidc_pkg::SEQ_RUN);
		ctrl = word;
		if (!busy || stall) begin
			ctrl.op   = pidc_pkg::OP_NOP;
			ctrl.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidc_pkg::SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == pidc_pkg::SEQ_IDLE) begin
				pc_q <= '0;
			end else if (!stall) begin
				pc_q <= pc_nxt;
			end
		end
	end

endmodule
